@@ hdl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication after a fixed number of cycles
`define ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/acg_pkg.sv @@
// types, constants and arithmetic helpers of the cdl colour grade
`default_nettype none

package acg_pkg;

    localparam int PIX_W           = 24;
    localparam int COEF_W          = 16;
    localparam int PIXEL_FRAC_BITS = 16;
    localparam int COEF_FRAC_BITS  = 12;
    localparam int LOG_FRAC        = 20;
    localparam int Y_W             = 31;
    localparam int R_W             = 32;
    localparam int M_W             = 5;
    localparam int LUMA_FRAC       = 16;
    localparam int LU_W            = 44;
    localparam int LUMA_W          = PIX_W + 1;
    localparam int SL_W            = PIX_W + COEF_W + 1;
    localparam int SA_W            = LUMA_W + COEF_W + 2;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 3 * COEF_W;
    localparam int POW_LAT         = 2 * LOG_FRAC + 3;
    localparam int TOP_LAT         = POW_LAT + 6;

    localparam int ALIGN_UP   = (PIXEL_FRAC_BITS >= COEF_FRAC_BITS) ?
                                PIXEL_FRAC_BITS - COEF_FRAC_BITS : 0;
    localparam int ALIGN_DN   = (PIXEL_FRAC_BITS >= COEF_FRAC_BITS) ?
                                0 : COEF_FRAC_BITS - PIXEL_FRAC_BITS;
    localparam int ALIGN_HALF = (ALIGN_DN > 0) ? (1 << (ALIGN_DN - 1)) : 0;

    localparam logic signed [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W-1){1'b1}}};
    localparam logic signed [PIX_W-1:0] PIX_MIN = {1'b1, {(PIX_W-1){1'b0}}};
    localparam logic signed [PIX_W-1:0] PIX_ONE = PIX_W'(1) << PIXEL_FRAC_BITS;

    localparam logic signed [LU_W-1:0] LUMA_R = 13933;
    localparam logic signed [LU_W-1:0] LUMA_G = 46871;
    localparam logic signed [LU_W-1:0] LUMA_B = 4732;

    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_ORDER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_CLAMP        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_RGB       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_RGB      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_RGB       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SATURATION_GAIN = 3'd5;

    localparam logic [COEF_W-1:0]     COEF_ONE  = COEF_W'(1) << COEF_FRAC_BITS;
    localparam logic [CFG_DATA_W-1:0] RGB_ONE   = {3{COEF_ONE}};

    typedef logic signed [PIX_W-1:0] t_pix;

    function automatic t_pix f_sat_pix(input logic signed [63:0] v);
        t_pix res;
        if (v > 64'(PIX_MAX)) begin
            res = PIX_MAX;
        end else if (v < 64'(PIX_MIN)) begin
            res = PIX_MIN;
        end else begin
            res = PIX_W'(v);
        end
        return res;
    endfunction

    function automatic t_pix f_clamp01(input t_pix x);
        t_pix res;
        if (x < 0) begin
            res = '0;
        end else if (x > PIX_ONE) begin
            res = PIX_ONE;
        end else begin
            res = x;
        end
        return res;
    endfunction

    function automatic t_pix f_slope(input t_pix x, input logic [COEF_W-1:0] s);
        logic signed [SL_W-1:0] prod;
        logic signed [SL_W-1:0] rnd;
        prod = SL_W'(x) * SL_W'(signed'({1'b0, s}));
        rnd  = (prod + (SL_W'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
        return f_sat_pix(64'(rnd));
    endfunction

    function automatic t_pix f_offset(input t_pix x, input logic [COEF_W-1:0] o);
        logic signed [31:0] oc;
        logic signed [31:0] al;
        logic signed [31:0] sum;
        oc  = 32'(signed'(o));
        al  = ((oc <<< ALIGN_UP) + 32'(ALIGN_HALF)) >>> ALIGN_DN;
        sum = 32'(x) + al;
        return f_sat_pix(64'(sum));
    endfunction

    function automatic logic signed [LUMA_W-1:0] f_luma(input t_pix r, input t_pix g,
                                                         input t_pix b);
        logic signed [LU_W-1:0] acc;
        acc = LU_W'(r) * LUMA_R + LU_W'(g) * LUMA_G + LU_W'(b) * LUMA_B
            + (LU_W'(1) <<< (LUMA_FRAC - 1));
        return LUMA_W'(acc >>> LUMA_FRAC);
    endfunction

    function automatic t_pix f_sat_apply(input logic [COEF_W-1:0] gain, input t_pix x,
                                         input logic signed [LUMA_W-1:0] luma);
        logic signed [LUMA_W:0]  d;
        logic signed [SA_W-1:0]  prod;
        logic signed [SA_W-1:0]  sum;
        d    = (LUMA_W + 1)'(x) - (LUMA_W + 1)'(luma);
        prod = SA_W'(d) * SA_W'(signed'({1'b0, gain}));
        sum  = ((prod + (SA_W'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS)
             + SA_W'(luma);
        return f_sat_pix(64'(sum));
    endfunction

    // 2^(2^-k) in q1.30 by repeated floor square roots
    function automatic logic [R_W-1:0] f_exp_root(input int k);
        logic [63:0] q;
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] b;
        q = 64'd1 << 31;
        for (int j = 0; j < LOG_FRAC; j++) begin
            if (j < k) begin
                n   = q << 30;
                res = '0;
                b   = 64'd1 << 62;
                for (int i = 0; i < 32; i++) begin
                    if (n >= res + b) begin
                        n   = n - (res + b);
                        res = (res >> 1) + b;
                    end else begin
                        res = res >> 1;
                    end
                    b = b >> 2;
                end
                q = res;
            end
        end
        return R_W'(q);
    endfunction

endpackage

`default_nettype wire

@@ hdl/acg_power.sv @@
// pipelined power unit: log2 by squaring, scale, exp2 by root products
`default_nettype none

module acg_power (
    input  logic                          i_clk,
    input  logic signed [acg_pkg::PIX_W-1:0] i_x,
    input  logic [acg_pkg::COEF_W-1:0]    i_power,
    input  logic                          i_no_clamp,
    output logic signed [acg_pkg::PIX_W-1:0] o_y
);
    import acg_pkg::*;

    localparam int LG_W = M_W + LOG_FRAC + 2;
    localparam int LP_W = LG_W + COEF_W + 1;
    localparam int T_W  = LP_W - COEF_FRAC_BITS;
    localparam int E_W  = T_W - LOG_FRAC;

    // normalise
    t_pix           n_v;
    logic [M_W-1:0] n_m;
    logic [Y_W-1:0] n_y0;

    always_comb begin
        n_v = i_no_clamp ? i_x : f_clamp01(i_x);
        n_m = '0;
        for (int k = 0; k < PIX_W; k++) begin
            if (n_v[k]) begin
                n_m = M_W'(k);
            end
        end
        n_y0 = Y_W'($unsigned(n_v)) << (M_W'(Y_W - 1) - n_m);
    end

    logic [Y_W-1:0]      r_ly [0:LOG_FRAC];
    logic [LOG_FRAC-1:0] r_lf [0:LOG_FRAC];
    logic [M_W-1:0]      r_lm [0:LOG_FRAC];
    logic                r_lb [0:LOG_FRAC];
    logic                r_lz [0:LOG_FRAC];
    t_pix                r_lv [0:LOG_FRAC];

    always_ff @(posedge i_clk) begin
        r_ly[0] <= n_y0;
        r_lf[0] <= '0;
        r_lm[0] <= n_m;
        r_lb[0] <= n_v[PIX_W-1];
        r_lz[0] <= (n_v == '0);
        r_lv[0] <= n_v;
    end

    // one log fraction bit per stage
    for (genvar g = 0; g < LOG_FRAC; g++) begin : g_log
        logic [2*Y_W-1:0] sq;
        logic [Y_W:0]     sq_sh;
        assign sq    = r_ly[g] * r_ly[g];
        assign sq_sh = sq[2*Y_W-1:Y_W-1];
        always_ff @(posedge i_clk) begin
            r_ly[g+1] <= sq_sh[Y_W] ? sq_sh[Y_W:1] : sq_sh[Y_W-1:0];
            r_lf[g+1] <= {r_lf[g][LOG_FRAC-2:0], sq_sh[Y_W]};
            r_lm[g+1] <= r_lm[g];
            r_lb[g+1] <= r_lb[g];
            r_lz[g+1] <= r_lz[g];
            r_lv[g+1] <= r_lv[g];
        end
    end

    // scale by exponent
    logic signed [LG_W-1:0] lg;
    logic signed [LP_W-1:0] lp;
    logic signed [T_W-1:0]  t;

    always_comb begin
        lg = ((LG_W'(r_lm[LOG_FRAC]) - LG_W'(PIXEL_FRAC_BITS)) <<< LOG_FRAC)
           + LG_W'(r_lf[LOG_FRAC]);
        lp = LP_W'(lg) * LP_W'(signed'({1'b0, i_power}));
        t  = T_W'((lp + (LP_W'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS);
    end

    logic signed [E_W-1:0] r_ee [0:LOG_FRAC];
    logic [LOG_FRAC-1:0]   r_ef [0:LOG_FRAC];
    logic [R_W-1:0]        r_er [0:LOG_FRAC];
    logic                  r_eb [0:LOG_FRAC];
    logic                  r_ez [0:LOG_FRAC];
    t_pix                  r_ev [0:LOG_FRAC];

    always_ff @(posedge i_clk) begin
        r_ee[0] <= E_W'(t >>> LOG_FRAC);
        r_ef[0] <= t[LOG_FRAC-1:0];
        r_er[0] <= R_W'(1) << (Y_W - 1);
        r_eb[0] <= r_lb[LOG_FRAC];
        r_ez[0] <= r_lz[LOG_FRAC];
        r_ev[0] <= r_lv[LOG_FRAC];
    end

    // one fraction bit of the exp2 per stage
    for (genvar g = 0; g < LOG_FRAC; g++) begin : g_exp
        localparam logic [R_W-1:0] QK = f_exp_root(g + 1);
        logic [2*R_W-1:0] prod;
        assign prod = r_er[g] * QK + ((2*R_W)'(1) << (Y_W - 2));
        always_ff @(posedge i_clk) begin
            r_er[g+1] <= r_ef[g][LOG_FRAC-1-g] ? prod[Y_W-1 +: R_W] : r_er[g];
            r_ee[g+1] <= r_ee[g];
            r_ef[g+1] <= r_ef[g];
            r_eb[g+1] <= r_eb[g];
            r_ez[g+1] <= r_ez[g];
            r_ev[g+1] <= r_ev[g];
        end
    end

    // final shift into pixel format
    logic signed [E_W-1:0] e;
    logic signed [E_W-1:0] sh;
    logic [63:0]           up;
    logic [5:0]            amt;
    logic [R_W:0]          dn;
    t_pix                  n_y;
    t_pix                  r_y;

    always_comb begin
        e   = r_ee[LOG_FRAC];
        sh  = e + E_W'(PIXEL_FRAC_BITS - (Y_W - 1));
        up  = 64'(r_er[LOG_FRAC]) << sh[4:0];
        amt = 6'(-sh);
        dn  = ((R_W + 1)'(r_er[LOG_FRAC]) + ((R_W + 1)'(1) << (amt - 6'd1))) >> amt;
        if (r_eb[LOG_FRAC]) begin
            n_y = r_ev[LOG_FRAC];
        end else if (r_ez[LOG_FRAC]) begin
            n_y = (i_power == '0) ? PIX_ONE : '0;
        end else if (e > E_W'(200) || sh >= E_W'(32)) begin
            n_y = PIX_MAX;
        end else if (sh >= 0) begin
            n_y = f_sat_pix(signed'(up));
        end else if (e < -E_W'(200) || sh <= -E_W'(33)) begin
            n_y = '0;
        end else begin
            n_y = f_sat_pix(64'(dn));
        end
    end

    always_ff @(posedge i_clk) begin
        r_y <= n_y;
    end

    assign o_y = r_y;

endmodule

`default_nettype wire

@@ hdl/asc_cdl_color_grade_unit.sv @@
// top level of the cdl colour grade: config registers and pixel pipeline
// the result strobe is registered through stages 1 to 3, the power units and posts 1 to 3
// throughput: one pixel per clock outside reset, set by the power unit, one multiplier per stage
// busy is high only while reset is held; results cannot be stalled
// reset is synchronous, active low: clears valid bits and loads the unity grade
`default_nettype none
`include "assert_macros.svh"

module asc_cdl_color_grade_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [acg_pkg::PIX_W-1:0]    i_red_in,
    input  logic signed [acg_pkg::PIX_W-1:0]    i_green_in,
    input  logic signed [acg_pkg::PIX_W-1:0]    i_blue_in,
    input  logic signed [acg_pkg::PIX_W-1:0]    i_alpha_in,
    input  logic                                i_cfg_we,
    input  logic [acg_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [acg_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    output logic                                o_done,
    output logic signed [acg_pkg::PIX_W-1:0]    o_red_out,
    output logic signed [acg_pkg::PIX_W-1:0]    o_green_out,
    output logic signed [acg_pkg::PIX_W-1:0]    o_blue_out,
    output logic signed [acg_pkg::PIX_W-1:0]    o_alpha_out
);
    import acg_pkg::*;

    logic                  r_reverse;
    logic                  r_no_clamp;
    logic [CFG_DATA_W-1:0] r_slope;
    logic [CFG_DATA_W-1:0] r_offset;
    logic [CFG_DATA_W-1:0] r_power;
    logic [COEF_W-1:0]     r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reverse  <= 1'b0;
            r_no_clamp <= 1'b0;
            r_slope    <= RGB_ONE;
            r_offset   <= '0;
            r_power    <= RGB_ONE;
            r_gain     <= COEF_ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REVERSE_ORDER: begin
                    r_reverse <= i_cfg_wdata[0];
                end
                CFG_NO_CLAMP: begin
                    r_no_clamp <= i_cfg_wdata[0];
                end
                CFG_SLOPE_RGB: begin
                    r_slope <= i_cfg_wdata;
                end
                CFG_OFFSET_RGB: begin
                    r_offset <= i_cfg_wdata;
                end
                CFG_POWER_RGB: begin
                    r_power <= i_cfg_wdata;
                end
                CFG_SATURATION_GAIN: begin
                    r_gain <= i_cfg_wdata[COEF_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    logic accept;
    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    // stage 1: slope, or input clamp in reverse
    t_pix n_s1_px [0:2];
    t_pix r_s1_px [0:2];
    t_pix r_s1_a;
    logic r_s1_vld;
    t_pix in_px [0:2];

    assign in_px[0] = i_red_in;
    assign in_px[1] = i_green_in;
    assign in_px[2] = i_blue_in;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (!r_reverse) begin
                n_s1_px[c] = f_slope(in_px[c], r_slope[COEF_W*c +: COEF_W]);
            end else begin
                n_s1_px[c] = r_no_clamp ? in_px[c] : f_clamp01(in_px[c]);
            end
        end
    end

    // stage 2: offset, or luma in reverse
    t_pix                       n_s2_px [0:2];
    t_pix                       r_s2_px [0:2];
    logic signed [LUMA_W-1:0]   r_s2_luma;
    t_pix                       r_s2_a;
    logic                       r_s2_vld;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_s2_px[c] = r_reverse ? r_s1_px[c]
                                   : f_offset(r_s1_px[c], r_offset[COEF_W*c +: COEF_W]);
        end
    end

    // stage 3: saturation in reverse
    t_pix n_s3_px [0:2];
    t_pix r_s3_px [0:2];
    logic r_s3_vld;
    t_pix r_s3_a;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_s3_px[c] = r_reverse ? f_sat_apply(r_gain, r_s2_px[c], r_s2_luma) : r_s2_px[c];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_s1_px[c] <= n_s1_px[c];
            r_s2_px[c] <= n_s2_px[c];
            r_s3_px[c] <= n_s3_px[c];
        end
        r_s1_a    <= i_alpha_in;
        r_s2_a    <= r_s1_a;
        r_s3_a    <= r_s2_a;
        r_s2_luma <= f_luma(r_s1_px[0], r_s1_px[1], r_s1_px[2]);
    end

    // power units and the matching delay line
    t_pix pw_px [0:2];

    for (genvar c = 0; c < 3; c++) begin : g_pow
        acg_power u_power (
            .i_clk      (i_clk),
            .i_x        (r_s3_px[c]),
            .i_power    (r_power[COEF_W*c +: COEF_W]),
            .i_no_clamp (r_no_clamp),
            .o_y        (pw_px[c])
        );
    end

    t_pix r_pd_a   [0:POW_LAT-1];
    logic r_pd_vld [0:POW_LAT-1];

    always_ff @(posedge i_clk) begin
        r_pd_a[0] <= r_s3_a;
        for (int i = 1; i < POW_LAT; i++) begin
            r_pd_a[i] <= r_pd_a[i-1];
        end
    end

    // post 1: luma, or offset in reverse
    t_pix                     n_p1_px [0:2];
    t_pix                     r_p1_px [0:2];
    logic signed [LUMA_W-1:0] r_p1_luma;
    t_pix                     r_p1_a;
    logic                     r_p1_vld;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_p1_px[c] = r_reverse ? f_offset(pw_px[c], r_offset[COEF_W*c +: COEF_W])
                                   : pw_px[c];
        end
    end

    // post 2: saturation, or slope in reverse
    t_pix n_p2_px [0:2];
    t_pix r_p2_px [0:2];
    t_pix r_p2_a;
    logic r_p2_vld;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_p2_px[c] = r_reverse ? f_slope(r_p1_px[c], r_slope[COEF_W*c +: COEF_W])
                                   : f_sat_apply(r_gain, r_p1_px[c], r_p1_luma);
        end
    end

    // post 3: output clamp, skipped when no_clamp is set
    t_pix n_p3_px [0:2];
    t_pix r_p3_px [0:2];
    t_pix r_p3_a;
    logic r_p3_vld;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_p3_px[c] = r_no_clamp ? r_p2_px[c] : f_clamp01(r_p2_px[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_p1_px[c] <= n_p1_px[c];
            r_p2_px[c] <= n_p2_px[c];
            r_p3_px[c] <= n_p3_px[c];
        end
        r_p1_luma <= f_luma(pw_px[0], pw_px[1], pw_px[2]);
        r_p1_a    <= r_pd_a[POW_LAT-1];
        r_p2_a    <= r_p1_a;
        r_p3_a    <= r_p2_a;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            for (int i = 0; i < POW_LAT; i++) begin
                r_pd_vld[i] <= 1'b0;
            end
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
        end else begin
            r_s1_vld    <= accept;
            r_s2_vld    <= r_s1_vld;
            r_s3_vld    <= r_s2_vld;
            r_pd_vld[0] <= r_s3_vld;
            for (int i = 1; i < POW_LAT; i++) begin
                r_pd_vld[i] <= r_pd_vld[i-1];
            end
            r_p1_vld <= r_pd_vld[POW_LAT-1];
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
        end
    end

    assign o_done      = r_p3_vld;
    assign o_red_out   = r_p3_px[0];
    assign o_green_out = r_p3_px[1];
    assign o_blue_out  = r_p3_px[2];
    assign o_alpha_out = r_p3_a;

    logic in_unit;
    assign in_unit = (o_red_out >= 0) && (o_red_out <= PIX_ONE)
                  && (o_green_out >= 0) && (o_green_out <= PIX_ONE)
                  && (o_blue_out >= 0) && (o_blue_out <= PIX_ONE);

    `ASSERT_DELAY(a_transfer_out, i_clk, i_rst_n, accept, TOP_LAT, o_done)
    `ASSERT_IMPLIES(a_done_has_src, i_clk, i_rst_n, o_done, $past(accept, TOP_LAT))
    `ASSERT_IMPLIES(a_clamp_range, i_clk, i_rst_n, o_done && !$past(r_no_clamp), in_unit)

endmodule

`default_nettype wire
